FILE: sv/line_edit_buffer_top_macros.svh
// Assertion macros shared by the line edit buffer RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef LINE_EDIT_BUFFER_TOP_MACROS_SVH
`define LINE_EDIT_BUFFER_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define LEB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define LEB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LEB_ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/leb_pkg.sv
// Package for the line edit buffer: sizes, command and key codes, types.
// Used by every RTL module of the block but leb_ram; depends on nothing.
`default_nettype none

package leb_pkg;

  // Line storage.
  localparam int LINE_CAPACITY = 80;
  localparam int PTR_W         = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int CHAR_W        = 7;
  localparam int KEY_W         = 8;
  localparam int CMD_W         = 2;
  localparam int WIDTH_W       = 7;

  localparam logic [PTR_W-1:0]   CAP_LEN           = PTR_W'(LINE_CAPACITY);
  localparam logic [WIDTH_W-1:0] FIELD_WIDTH_RESET = WIDTH_W'(40);

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // Key codes.
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd15;
  localparam logic [KEY_W-1:0] KEY_DELETE    = 8'd3;
  localparam logic [KEY_W-1:0] KEY_CLEAR     = 8'd7;
  localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'd9;
  localparam logic [KEY_W-1:0] KEY_LEFT      = 8'd8;
  localparam logic [KEY_W-1:0] KEY_HOME      = 8'd147;
  localparam logic [KEY_W-1:0] KEY_END       = 8'd132;
  localparam logic [KEY_W-1:0] KEY_PRINT_LO  = 8'd32;
  localparam logic [KEY_W-1:0] KEY_PRINT_HI  = 8'd126;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_READ,
    ST_DONE
  } ctrl_state_t;

  // Kind of shift pass over the line memory.
  typedef enum logic {
    OP_REMOVE,
    OP_INSERT
  } shift_op_t;

  // Result of one item as handed from the sequencer to the view stage.
  typedef struct packed {
    logic [PTR_W-1:0]  cursor;
    logic [PTR_W-1:0]  length;
    logic              redraw;
    logic [CHAR_W-1:0] rd_char;
  } leb_result_t;

endpackage

`default_nettype wire

FILE: sv/line_edit_buffer_top.sv
// Line edit buffer: one editable text line with cursor and horizontal view.
// Use: items enter on the in channel (cmd, key_code, position); each item
// gives exactly one result on the out channel. The field width register is
// written by a transfer on the cfg channel, which is always ready. The user
// must write it only while no item is in flight; the block does not enforce
// this. Reset empties the line, puts the cursor at 0 and sets the field
// width to 40; the character RAM itself is not cleared.
// Flow: an item is taken in the idle state. Cursor moves, set-cursor and
// ignored keys go from idle straight to the done state; a read inside the
// line passes through the read state first, a read past its end does not.
// Backspace, delete and insert run a shift pass through the character RAM,
// one character a cycle, before the done state. The view stage holds the
// result in its two registers before it appears. The next item is taken once
// the sequencer has handed its result to the view stage, so a result may
// wait on the out channel while the next item is already at work. When the
// receiver stalls, results back up through the two view registers and then
// the sequencer holds, with in_ready low, until the out channel moves again.
// Depends on leb_pkg, leb_ctrl, leb_view and leb_ram.
`default_nettype none

module line_edit_buffer_top
  import leb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CMD_W-1:0]     cmd,
  input  wire logic [KEY_W-1:0]     key_code,
  input  wire logic [PTR_W-1:0]     position,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [PTR_W-1:0]     cursor_pos,
  output logic      [PTR_W-1:0]     line_length,
  output logic                      redraw,
  output logic      [CHAR_W-1:0]    read_char,
  output logic      [PTR_W-1:0]     scroll_offset,
  output logic      [PTR_W-1:0]     visible_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [WIDTH_W-1:0]   field_width
);

  logic        res_valid;
  logic        res_ready;
  leb_result_t res;

  // Item sequencer with the character store.
  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .key_code  (key_code),
    .position  (position),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // View arithmetic and output register.
  leb_view u_view (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .field_width   (field_width),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_pos    (cursor_pos),
    .line_length   (line_length),
    .redraw        (redraw),
    .read_char     (read_char),
    .scroll_offset (scroll_offset),
    .visible_count (visible_count)
  );

endmodule

`default_nettype wire

FILE: sv/leb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the character store of the line edit buffer.
`default_nettype none

module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/leb_ctrl.sv
// Sequencer of the line edit buffer: decodes items, keeps cursor and length,
// and runs shift passes over the character RAM. Depends on leb_pkg, leb_ram.
`default_nettype none

`include "line_edit_buffer_top_macros.svh"

module leb_ctrl
  import leb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [KEY_W-1:0]   key_code,
  input  wire logic [PTR_W-1:0]   position,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output leb_result_t             res
);

  ctrl_state_t state, state_next;
  shift_op_t   op, op_next;

  logic [PTR_W-1:0]  cursor, cursor_next;
  logic [PTR_W-1:0]  length, length_next;
  logic [PTR_W-1:0]  idx, idx_next;
  logic              pend, pend_next;
  logic [PTR_W-1:0]  pend_dst, pend_dst_next;
  logic [CHAR_W-1:0] key_char, key_char_next;
  logic              dec_cursor, dec_cursor_next;
  logic              redraw, redraw_next;
  logic [CHAR_W-1:0] rd_char, rd_char_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              accept;
  logic              more;
  logic              printable;
  logic [PTR_W:0]    idx_inc;

  // Character store.
  leb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = in_valid && in_ready;
  assign idx_inc   = {1'b0, idx} + {{PTR_W{1'b0}}, 1'b1};
  assign printable = (key_code >= KEY_PRINT_LO) && (key_code <= KEY_PRINT_HI);

  // A shift pass has another step while the destination stays inside the range.
  assign more = (op == OP_REMOVE) ? (idx_inc < {1'b0, length}) : (idx > cursor);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DONE;
          if (cmd == CMD_READ) begin
            if (position < length) begin
              state_next = ST_READ;
            end
          end else if (cmd == CMD_KEY) begin
            case (key_code)
              KEY_BACKSPACE: begin
                if (cursor != '0) begin
                  state_next = ST_SHIFT;
                end
              end
              KEY_DELETE: begin
                if (cursor < length) begin
                  state_next = ST_SHIFT;
                end
              end
              KEY_CLEAR, KEY_RIGHT, KEY_LEFT, KEY_HOME, KEY_END: begin
                state_next = ST_DONE;
              end
              default: begin
                if (printable && (length < CAP_LEN)) begin
                  state_next = ST_SHIFT;
                end
              end
            endcase
          end
        end
      end
      ST_SHIFT: begin
        if (!more && !pend) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ready        = (state == ST_IDLE);
    res_valid       = (state == ST_DONE);
    cursor_next     = cursor;
    length_next     = length;
    idx_next        = idx;
    op_next         = op;
    pend_next       = 1'b0;
    pend_dst_next   = pend_dst;
    key_char_next   = key_char;
    dec_cursor_next = dec_cursor;
    redraw_next     = redraw;
    rd_char_next    = rd_char;
    ram_we          = 1'b0;
    ram_waddr       = pend_dst[ADDR_W-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = position[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          redraw_next     = 1'b0;
          rd_char_next    = '0;
          dec_cursor_next = 1'b0;
          key_char_next   = key_code[CHAR_W-1:0];
          case (cmd)
            CMD_KEY: begin
              case (key_code)
                KEY_BACKSPACE: begin
                  if (cursor != '0) begin
                    op_next         = OP_REMOVE;
                    idx_next        = cursor - PTR_W'(1);
                    dec_cursor_next = 1'b1;
                    redraw_next     = 1'b1;
                  end
                end
                KEY_DELETE: begin
                  if (cursor < length) begin
                    op_next     = OP_REMOVE;
                    idx_next    = cursor;
                    redraw_next = 1'b1;
                  end
                end
                KEY_CLEAR: begin
                  cursor_next = '0;
                  length_next = '0;
                  redraw_next = 1'b1;
                end
                KEY_RIGHT: begin
                  if (cursor < length) begin
                    cursor_next = cursor + PTR_W'(1);
                  end
                  redraw_next = 1'b1;
                end
                KEY_LEFT: begin
                  if (cursor != '0) begin
                    cursor_next = cursor - PTR_W'(1);
                  end
                  redraw_next = 1'b1;
                end
                KEY_HOME: begin
                  cursor_next = '0;
                  redraw_next = 1'b1;
                end
                KEY_END: begin
                  cursor_next = length;
                  redraw_next = 1'b1;
                end
                default: begin
                  if (printable && (length < CAP_LEN)) begin
                    op_next     = OP_INSERT;
                    idx_next    = length;
                    redraw_next = 1'b1;
                  end
                end
              endcase
            end
            CMD_SET: begin
              cursor_next = (position > length) ? length : position;
              redraw_next = 1'b1;
            end
            CMD_READ: begin
              ram_raddr = position[ADDR_W-1:0];
            end
            default: begin
              redraw_next = 1'b0;
            end
          endcase
        end
      end

      // One step a cycle: read the source now, write the data read last cycle.
      ST_SHIFT: begin
        ram_we = pend;
        if (more) begin
          pend_next     = 1'b1;
          pend_dst_next = idx;
          if (op == OP_REMOVE) begin
            ram_raddr = idx_inc[ADDR_W-1:0];
            idx_next  = idx_inc[PTR_W-1:0];
          end else begin
            ram_raddr = ADDR_W'(idx - PTR_W'(1));
            idx_next  = idx - PTR_W'(1);
          end
        end else if (!pend) begin
          if (op == OP_INSERT) begin
            ram_we      = 1'b1;
            ram_waddr   = cursor[ADDR_W-1:0];
            ram_wdata   = key_char;
            cursor_next = cursor + PTR_W'(1);
            length_next = length + PTR_W'(1);
          end else begin
            length_next = length - PTR_W'(1);
            if (dec_cursor) begin
              cursor_next = cursor - PTR_W'(1);
            end
          end
        end
      end

      ST_READ: begin
        rd_char_next = ram_rdata;
      end

      ST_DONE: begin
        pend_next = 1'b0;
      end

      default: begin
        pend_next = 1'b0;
      end
    endcase
  end

  // Result handed to the view stage.
  always_comb begin
    res.cursor  = cursor;
    res.length  = length;
    res.redraw  = redraw;
    res.rd_char = rd_char;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cursor <= '0;
      length <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      length <= length_next;
      pend   <= pend_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    op         <= op_next;
    idx        <= idx_next;
    pend_dst   <= pend_dst_next;
    key_char   <= key_char_next;
    dec_cursor <= dec_cursor_next;
    redraw     <= redraw_next;
    rd_char    <= rd_char_next;
  end

  // The line never grows beyond its capacity.
  `LEB_ASSERT_ALWAYS(a_len_cap, length <= CAP_LEN, "line length exceeds capacity")
  // The cursor never passes the end of the line.
  `LEB_ASSERT_ALWAYS(a_cur_len, cursor <= length, "cursor beyond line length")
  // The character store is only written during a shift pass.
  `LEB_ASSERT_IMPLY(a_we_shift, ram_we, state == ST_SHIFT, "RAM write outside shift pass")
  // A result that is not taken is held unchanged.
  `LEB_ASSERT_IMPLY_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

endmodule

`default_nettype wire

FILE: sv/leb_view.sv
// View stage of the line edit buffer: holds the field width register and
// works out scroll offset and visible count. Depends on leb_pkg.
`default_nettype none

module leb_view
  import leb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [WIDTH_W-1:0]   field_width,
  input  wire logic                 res_valid,
  output logic                      res_ready,
  input  wire leb_result_t          res,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [PTR_W-1:0]     cursor_pos,
  output logic      [PTR_W-1:0]     line_length,
  output logic                      redraw,
  output logic      [CHAR_W-1:0]    read_char,
  output logic      [PTR_W-1:0]     scroll_offset,
  output logic      [PTR_W-1:0]     visible_count
);

  logic [WIDTH_W-1:0] width_cfg;
  logic               s1_valid;
  leb_result_t        s1;
  logic [PTR_W-1:0]   s1_scroll;
  logic [PTR_W-1:0]   scroll_calc;
  logic [PTR_W-1:0]   vis_diff;
  logic [PTR_W-1:0]   vis_calc;
  logic               s1_adv;
  logic               take;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign res_ready = !s1_valid || s1_adv;
  assign take      = res_valid && res_ready;

  // Scroll offset: first visible index once the cursor reaches the width.
  always_comb begin
    if (res.cursor >= width_cfg) begin
      scroll_calc = res.cursor - width_cfg + PTR_W'(1);
    end else begin
      scroll_calc = '0;
    end
  end

  // Visible count: what lies beyond the offset, capped at the width.
  always_comb begin
    vis_diff = s1.length - s1_scroll;
    if (s1.length > s1_scroll) begin
      vis_calc = (vis_diff > width_cfg) ? width_cfg : vis_diff;
    end else begin
      vis_calc = '0;
    end
  end

  // Field width register, written by a transfer on the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg <= FIELD_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_cfg <= field_width;
    end
  end

  // Valid flags of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the two stages.
  always_ff @(posedge clk) begin
    if (take) begin
      s1        <= res;
      s1_scroll <= scroll_calc;
    end
    if (s1_adv) begin
      cursor_pos    <= s1.cursor;
      line_length   <= s1.length;
      redraw        <= s1.redraw;
      read_char     <= s1.rd_char;
      scroll_offset <= s1_scroll;
      visible_count <= vis_calc;
    end
  end

endmodule

`default_nettype wire
